// File: rtl/assert_macros.svh
// Assertion macros used by the top level RTL file of the histogram peak distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// File: rtl/dhpd_pkg.sv
// Package with the types and constants of the histogram peak distance block.
package dhpd_pkg;

    localparam int PIX_W    = 8;
    localparam int NUM_BINS = 256;
    localparam int DEPTH_W  = 20;
    localparam int NDISP_W  = 8;
    localparam int THR_W    = 4;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 20;
    localparam int DEN_W    = PIX_W + NDISP_W;
    localparam int DIV_W    = DEPTH_W + 8;
    localparam int DIV_CW   = 5;

    localparam int MEAN_SCALE    = 153;
    localparam int LOW_BINS_ZERO = 4;
    localparam int MIN_PEAK_BIN  = 3;

    localparam logic [DEPTH_W-1:0] DIST_MAX      = 20'hFFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_NUM_RST = 20'd76500;
    localparam logic [NDISP_W-1:0] NUM_DISP_RST  = 8'd48;
    localparam logic [THR_W-1:0]   RATIO_THR_RST = 4'd4;
    localparam logic [DIV_CW-1:0]  DIV_LAST      = 5'(DIV_W - 1);

    localparam logic [CFG_AW-1:0] CFG_DEPTH_NUM = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_NUM_DISP  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_RATIO_THR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_RATIO1,
        ST_RATIO2,
        ST_RATIO3,
        ST_RATIO4,
        ST_DIV,
        ST_OUT
    } dhpd_state_t;

endpackage

// File: rtl/disparity_histogram_peak_distance_top.sv
// Top level of the disparity histogram peak distance block.
// For each disparity pixel request, the bin is read from the histogram
// memory and written back incremented on the next cycle. The pixel marked
// last then starts the bin scan through the same memory read port and the
// ratio test, followed by the one-bit-per-cycle divider when an object is
// found, before the result is loaded into the output register. The
// histogram is cleared at once when the result is loaded, through one valid
// bit per bin. While a result waits in the output register, the next
// region's pixels are taken.
`include "assert_macros.svh"

module disparity_histogram_peak_distance_top #(
    parameter int SCAN_LIMIT = 208,
    parameter int MAX_PIXELS = 65536
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [dhpd_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [dhpd_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: disparity_pixel [7:0].
    input  logic [7:0]                   s_tdata,
    // s_tlast: last_pixel.
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: peak_bin [7:0], distance_fixed [27:8], zero fill [31:28].
    output logic [31:0]                  m_tdata,
    // m_tuser: object_found.
    output logic                         m_tuser
);

    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W  = $clog2(SCAN_LIMIT * MAX_PIXELS + 1);
    localparam int PROD_W = SUM_W + 9;
    localparam int CMP_W  = PROD_W + 9;
    localparam logic [7:0]       SCAN_LAST = 8'(SCAN_LIMIT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_PIXELS);

    dhpd_pkg::dhpd_state_t state_reg, state_next;

    logic [dhpd_pkg::DEPTH_W-1:0] depth_num_reg;
    logic [dhpd_pkg::NDISP_W-1:0] ndisp_reg;
    logic [dhpd_pkg::THR_W-1:0]   ratio_thr_reg;

    logic [CNT_W-1:0]    mem [dhpd_pkg::NUM_BINS];
    logic [dhpd_pkg::NUM_BINS-1:0] valid_reg;
    logic [7:0]          rd_addr;
    logic [CNT_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;
    logic [CNT_W-1:0]    cur_cnt;
    logic [CNT_W-1:0]    inc_cnt;

    logic [7:0]          pix_reg;
    logic                last_reg;
    logic [7:0]          scan_idx_reg;
    logic                acc_vld_reg;
    logic [7:0]          acc_idx_reg;
    logic [CNT_W-1:0]    bin_val;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    peak_reg;
    logic [7:0]          peak_idx_reg;

    logic [PROD_W-1:0]        a_reg;
    logic [PROD_W-1:0]        b_reg;
    logic signed [PROD_W:0]   mean_reg;
    logic [CMP_W-1:0]         lhs_reg;
    logic [CMP_W-1:0]         rhs_reg;
    logic                     found_reg;
    logic                     found_calc;

    logic [dhpd_pkg::DEN_W-1:0]  den_reg;
    logic [dhpd_pkg::DEN_W-1:0]  rem_reg;
    logic [dhpd_pkg::DIV_W-1:0]  num_reg;
    logic [dhpd_pkg::DIV_CW-1:0] div_cnt_reg;
    logic [dhpd_pkg::DEN_W:0]    trial;
    logic [dhpd_pkg::DEN_W:0]    diff;
    logic                        ge;

    logic                         m_tvalid_reg;
    logic                         out_found_reg;
    logic [7:0]                   out_peak_reg;
    logic [dhpd_pkg::DEPTH_W-1:0] out_dist_reg;
    logic [dhpd_pkg::DEPTH_W-1:0] dist_val;
    logic                         load_out;
    logic                         in_acc;

    assign s_tready = (state_reg == dhpd_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign load_out = (state_reg == dhpd_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {4'b0, out_dist_reg, out_peak_reg};

    assign rd_addr = (state_reg == dhpd_pkg::ST_SCAN) ? scan_idx_reg : s_tdata;
    assign cur_cnt = rd_vld_reg ? rd_data_reg : '0;
    assign inc_cnt = (cur_cnt < CNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
    assign bin_val = (acc_idx_reg < 8'(dhpd_pkg::LOW_BINS_ZERO)) ? '0 : cur_cnt;

    assign found_calc = (peak_reg != '0) &&
                        ((mean_reg == '0) || (!mean_reg[PROD_W] && (lhs_reg > rhs_reg)));

    assign trial = {rem_reg, num_reg[dhpd_pkg::DIV_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        if (!found_reg)
        begin
            dist_val = '0;
        end
        else if ((den_reg == '0) || (num_reg[dhpd_pkg::DIV_W-1:dhpd_pkg::DEPTH_W] != '0))
        begin
            dist_val = dhpd_pkg::DIST_MAX;
        end
        else
        begin
            dist_val = num_reg[dhpd_pkg::DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dhpd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhpd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = dhpd_pkg::ST_UPD;
                end
            end
            dhpd_pkg::ST_UPD:
            begin
                state_next = last_reg ? dhpd_pkg::ST_SCAN : dhpd_pkg::ST_IDLE;
            end
            dhpd_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == SCAN_LAST)
                begin
                    state_next = dhpd_pkg::ST_DRAIN;
                end
            end
            dhpd_pkg::ST_DRAIN:  state_next = dhpd_pkg::ST_RATIO1;
            dhpd_pkg::ST_RATIO1: state_next = dhpd_pkg::ST_RATIO2;
            dhpd_pkg::ST_RATIO2: state_next = dhpd_pkg::ST_RATIO3;
            dhpd_pkg::ST_RATIO3: state_next = dhpd_pkg::ST_RATIO4;
            dhpd_pkg::ST_RATIO4:
            begin
                state_next = found_calc ? dhpd_pkg::ST_DIV : dhpd_pkg::ST_OUT;
            end
            dhpd_pkg::ST_DIV:
            begin
                if (div_cnt_reg == dhpd_pkg::DIV_LAST)
                begin
                    state_next = dhpd_pkg::ST_OUT;
                end
            end
            dhpd_pkg::ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = dhpd_pkg::ST_IDLE;
                end
            end
            default: state_next = dhpd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_num_reg <= dhpd_pkg::DEPTH_NUM_RST;
            ndisp_reg     <= dhpd_pkg::NUM_DISP_RST;
            ratio_thr_reg <= dhpd_pkg::RATIO_THR_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                dhpd_pkg::CFG_DEPTH_NUM: depth_num_reg <= cfg_wdata[dhpd_pkg::DEPTH_W-1:0];
                dhpd_pkg::CFG_NUM_DISP:  ndisp_reg     <= cfg_wdata[dhpd_pkg::NDISP_W-1:0];
                dhpd_pkg::CFG_RATIO_THR: ratio_thr_reg <= cfg_wdata[dhpd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (state_reg == dhpd_pkg::ST_UPD)
        begin
            mem[pix_reg] <= inc_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            acc_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= valid_reg[rd_addr];
            acc_vld_reg <= (state_reg == dhpd_pkg::ST_SCAN);
            if (state_reg == dhpd_pkg::ST_UPD)
            begin
                valid_reg[pix_reg] <= 1'b1;
            end
            else if (load_out)
            begin
                valid_reg <= '0;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_reg  <= s_tdata;
            last_reg <= s_tlast;
        end
        if (acc_vld_reg)
        begin
            sum_reg     <= sum_reg + SUM_W'(bin_val);
            if ((acc_idx_reg >= 8'(dhpd_pkg::MIN_PEAK_BIN)) && (bin_val >= peak_reg))
            begin
                peak_reg     <= bin_val;
                peak_idx_reg <= acc_idx_reg;
            end
        end
        if (load_out)
        begin
            out_found_reg <= found_reg;
            out_peak_reg  <= peak_idx_reg;
            out_dist_reg  <= dist_val;
        end
        unique case (state_reg)
            dhpd_pkg::ST_UPD:
            begin
                scan_idx_reg <= '0;
                sum_reg      <= '0;
                peak_reg     <= '0;
                peak_idx_reg <= '0;
            end
            dhpd_pkg::ST_SCAN:
            begin
                acc_idx_reg  <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            dhpd_pkg::ST_RATIO1:
            begin
                a_reg <= PROD_W'(sum_reg) * PROD_W'(dhpd_pkg::MEAN_SCALE);
                b_reg <= PROD_W'(peak_reg) * PROD_W'(SCAN_LIMIT);
            end
            dhpd_pkg::ST_RATIO2:
            begin
                mean_reg <= $signed({1'b0, a_reg}) - $signed({1'b0, b_reg});
                lhs_reg  <= CMP_W'(b_reg) * CMP_W'(dhpd_pkg::MEAN_SCALE);
            end
            dhpd_pkg::ST_RATIO3:
            begin
                rhs_reg <= CMP_W'(ratio_thr_reg) * CMP_W'(mean_reg[PROD_W-1:0]);
            end
            dhpd_pkg::ST_RATIO4:
            begin
                found_reg   <= found_calc;
                den_reg     <= dhpd_pkg::DEN_W'(peak_idx_reg) * dhpd_pkg::DEN_W'(ndisp_reg);
                num_reg     <= {depth_num_reg, 8'b0};
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            dhpd_pkg::ST_DIV:
            begin
                rem_reg     <= ge ? diff[dhpd_pkg::DEN_W-1:0] : trial[dhpd_pkg::DEN_W-1:0];
                num_reg     <= {num_reg[dhpd_pkg::DIV_W-2:0], ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    `ASSERT_CLKD(a_accept_to_upd, in_acc |=> (state_reg == dhpd_pkg::ST_UPD),
                 "accepted pixel did not go to the update cycle")
    `ASSERT_CLKD(a_rose_from_out, $rose(m_tvalid) |-> $past(state_reg == dhpd_pkg::ST_OUT),
                 "result appeared without the output load state")
    `ASSERT_CLKD(a_not_found_zero, (m_tvalid && !m_tuser) |-> (m_tdata[27:8] == '0),
                 "distance nonzero while no object found")
    `ASSERT_CLKD(a_peak_range,
                 m_tvalid |-> ((m_tdata[7:0] >= 8'(dhpd_pkg::MIN_PEAK_BIN)) && (m_tdata[7:0] <= SCAN_LAST)),
                 "peak bin outside the scanned range")
    `ASSERT_ANY(a_busy_no_ready, (state_reg == dhpd_pkg::ST_DIV) |-> !s_tready,
                "pixel ready during the divide")

endmodule
